### hw/rtl/sdedup_pkg.sv
// Shared types and constants for the stream duplicate-removal block.
// Used by sdedup_ctrl, sdedup_dp and stream_dedup_keep_first; no dependencies.
package sdedup_pkg;

  localparam int DefCapacity = 64;
  localparam int ValueW      = 32;
  localparam int UserW       = 2;

  // Bit positions inside the result tuser field.
  localparam int UserKeepBit = 0;
  localparam int UserOvfBit  = 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/sdedup_ctrl.sv
// Controller state machine for the duplicate-removal block.
// Depends on sdedup_pkg; drives commands to sdedup_dp and reads its status.
module sdedup_ctrl import sdedup_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/sdedup_dp.sv
// Datapath for the duplicate-removal block: value table memory, scan pointer,
// entry count and the result register. Depends on sdedup_pkg.
module sdedup_dp import sdedup_pkg::*; #(
  parameter int Capacity = DefCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [ValueW-1:0] in_data_i,
  input  logic              in_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] out_data_o,
  output logic              out_last_o,
  output logic [UserW-1:0]  out_user_o
);

  localparam int CntW = $clog2(Capacity + 1);
  localparam int IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam logic [CntW-1:0] CapC = CntW'(Capacity);

  logic [ValueW-1:0] mem [Capacity];

  logic [ValueW-1:0] value_q;
  logic              last_q;
  logic [CntW-1:0]   idx_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [ValueW-1:0] rd_data_q;
  logic              rd_vld_q;
  logic              hit_q;
  logic              out_valid_q;
  logic [ValueW-1:0] out_data_q;
  logic              out_last_q;
  logic [UserW-1:0]  out_user_q;

  logic more;
  logic full;
  logic store;

  assign more  = idx_q < count_q;
  assign full  = count_q >= CapC;
  assign store = cmd_i.finish && !hit_q && !full;

  // Table memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && more) begin
      rd_data_q <= mem[idx_q[IdxW-1:0]];
    end
    if (store) begin
      mem[count_q[IdxW-1:0]] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= in_data_i;
      last_q  <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.scan) begin
      rd_vld_q <= more;
      if (more) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (rd_vld_q && (rd_data_q == value_q)) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.finish) begin
      if (last_q) begin
        count_d = '0;
      end else if (store) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q              <= value_q;
      out_last_q              <= last_q;
      out_user_q[UserKeepBit] <= !hit_q;
      out_user_q[UserOvfBit]  <= !hit_q && full;
    end
  end

  assign sts_o.scan_done = hit_q || (!more && !rd_vld_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_user_o  = out_user_q;

endmodule

### hw/rtl/stream_dedup_keep_first.sv
// Top level of the order-preserving duplicate-removal block.
// Depends on sdedup_pkg, sdedup_ctrl and sdedup_dp.
//
// The block takes one signed 32-bit value per input beat on the s_axis
// channel, with tlast marking the final value of a sequence. Every input beat
// gives exactly one output beat on the m_axis channel carrying the same value,
// the same tlast, a keep flag set when the value is not found in the table for
// the current sequence, and an overflow flag set when a new value could not
// be recorded because the table already holds Capacity entries.
// Each item is compared against the values recorded so far, at most Capacity,
// one table memory read per cycle; a match ends the search early. The next
// beat is accepted in the cycle after the result is loaded into the output
// register. Reset empties the table at once; no clearing pass is needed since
// only entries below the count are read. When the receiver stalls, the result
// is held in the output register and one further item is taken and searched,
// then the block waits until that register is free.
module stream_dedup_keep_first import sdedup_pkg::*; #(
  parameter int Capacity = DefCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ValueW-1:0] s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tlast,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ValueW-1:0] m_axis_tdata,   // [31:0] value_out
  output logic              m_axis_tlast,
  output logic [UserW-1:0]  m_axis_tuser    // [0] keep, [1] overflow
);

  cmd_t cmd;
  sts_t sts;

  sdedup_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  sdedup_dp #(
    .Capacity (Capacity)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser)
  );

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("Result loaded while the output register was occupied.");

  a_load_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!cmd.scan && !cmd.finish))
    else $error("Load command overlaps scan or finish.");

  a_no_immediate_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !cmd.finish)
    else $error("Result produced without a table search.");

  a_finish_shows_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid)
    else $error("Finished item did not appear on the output.");

endmodule
